// ===== rtl/bvavg_pkg.sv =====
// bvavg_pkg: shared types and constants of the battery voltage averager
// no dependencies; used by battery_voltage_averager
package bvavg_pkg;

	localparam int HISTORY_DEPTH_DEF = 8;

	localparam int SAMPLE_W    = 12;
	localparam int MV_W        = 16;
	localparam int GAIN_W      = 16;
	localparam int GAIN_FRAC_W = 12;
	localparam int BURST_W     = 8;
	localparam int BURST_SUM_W = 20;
	localparam int PROD_W      = SAMPLE_W + GAIN_W;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 40;

	localparam logic [BURST_W-1:0] BURST_SAMPLES_RST = 8'd16;
	localparam logic [GAIN_W-1:0]  GAIN_RST          = 16'd8192;
	localparam logic [MV_W-1:0]    LOW_THR_RST       = 16'd3500;
	localparam logic [MV_W-1:0]    CRIT_THR_RST      = 16'd3300;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BURST_SAMPLES,
		REG_GAIN,
		REG_LOW_THR,
		REG_CRIT_THR
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_MEAN,
		ST_MUL,
		ST_WRITE,
		ST_DIV_AVG,
		ST_EMIT
	} state_t;

endpackage

// ===== rtl/battery_voltage_averager.sv =====
// battery_voltage_averager: burst mean, q4.12 scaling, history ring average, threshold flags
// depends on bvavg_pkg and bvavg_ram
// a sample that does not close a burst is only added to the burst sum and count; a closing
// sample starts the mean division, then scaling, the ring write and the average division follow;
// both divisions run on the shared restoring divider that makes one quotient bit per cycle
// the input stays closed until the result word is loaded and while the previous one is held
// arst_n clears config to defaults, burst and ring counters and sums; the ring ram is not cleared
module battery_voltage_averager #(
	parameter int HISTORY_DEPTH = bvavg_pkg::HISTORY_DEPTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [bvavg_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // sample_mv[11:0], zero pad
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [bvavg_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // reading_mv[15:0],
	                                                            // average_mv[31:16],
	                                                            // is_low[32], is_critical[33]
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [bvavg_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bvavg_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import bvavg_pkg::*;

	localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
	localparam int SUM_W = MV_W + ((HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 0);
	localparam int DIV_W = (SUM_W > BURST_SUM_W) ? SUM_W : BURST_SUM_W;
	localparam int DCNT_W = $clog2(DIV_W + 1);

	// config
	logic [BURST_W-1:0] burst_samples_q;
	logic [GAIN_W-1:0]  gain_q;
	logic [MV_W-1:0]    low_thr_q;
	logic [MV_W-1:0]    crit_thr_q;

	state_t state_q, state_d;

	logic [BURST_SUM_W-1:0] burst_sum_q;
	logic [BURST_W-1:0]     burst_count_q;
	logic [PTR_W-1:0]       wr_ptr_q;
	logic [CNT_W-1:0]       fill_q;
	logic [SUM_W-1:0]       hist_sum_q;

	// divider
	logic [DIV_W-1:0]   div_quo_q;
	logic [BURST_W-1:0] div_rem_q;
	logic [BURST_W-1:0] div_den_q;
	logic [DCNT_W-1:0]  div_cnt_q;
	logic [BURST_W:0]   div_trial;
	logic               div_ge;
	logic [BURST_W-1:0] div_rem_nxt;

	logic [PROD_W-1:0] product_q;
	logic [MV_W-1:0]   reading_q;

	logic              out_valid_q;
	logic [MV_W-1:0]   out_reading_q;
	logic [MV_W-1:0]   out_avg_q;
	logic              out_low_q;
	logic              out_crit_q;

	logic                   in_fire;
	logic [SAMPLE_W-1:0]    sample;
	logic [BURST_SUM_W-1:0] sum_new;
	logic [BURST_W-1:0]     count_new;
	logic [BURST_W-1:0]     target;
	logic                   burst_done;
	logic                   full;
	logic [CNT_W-1:0]       fill_new;
	logic [SUM_W-1:0]       hist_sum_new;
	logic [MV_W-1:0]        reading;
	logic [MV_W-1:0]        old_entry;
	logic [MV_W-1:0]        average;
	logic                   out_free;
	logic                   ram_we;

	assign sample     = s_axis_tdata[SAMPLE_W-1:0];
	assign in_fire    = s_axis_tvalid && s_axis_tready;
	assign sum_new    = burst_sum_q + BURST_SUM_W'(sample);
	assign count_new  = burst_count_q + BURST_W'(1);
	assign target     = (burst_samples_q == '0) ? BURST_W'(1) : burst_samples_q;
	assign burst_done = count_new >= target;

	assign full         = fill_q == CNT_W'(HISTORY_DEPTH);
	assign fill_new     = full ? fill_q : fill_q + CNT_W'(1);
	assign reading      = product_q[PROD_W-1:GAIN_FRAC_W];
	assign hist_sum_new = hist_sum_q - (full ? SUM_W'(old_entry) : '0) + SUM_W'(reading);
	assign average      = div_quo_q[MV_W-1:0];
	assign out_free     = !out_valid_q || m_axis_tready;
	assign ram_we       = state_q == ST_WRITE;

	assign div_trial   = {div_rem_q, div_quo_q[DIV_W-1]};
	assign div_ge      = div_trial >= {1'b0, div_den_q};
	assign div_rem_nxt = div_ge ? BURST_W'(div_trial - {1'b0, div_den_q})
	                            : div_trial[BURST_W-1:0];

	assign s_axis_tready = state_q == ST_IDLE;
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'b0, out_crit_q, out_low_q, out_avg_q, out_reading_q};

	bvavg_ram #(
		.WIDTH (MV_W),
		.DEPTH (HISTORY_DEPTH)
	) u_history (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_ptr_q),
		.wdata (reading),
		.raddr (wr_ptr_q),
		.rdata (old_entry)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire && burst_done) state_d = ST_DIV_MEAN;
			end
			ST_DIV_MEAN: begin
				if (div_cnt_q == DCNT_W'(1)) state_d = ST_MUL;
			end
			ST_MUL: begin
				state_d = ST_WRITE;
			end
			ST_WRITE: begin
				state_d = ST_DIV_AVG;
			end
			ST_DIV_AVG: begin
				if (div_cnt_q == DCNT_W'(1)) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_samples_q <= BURST_SAMPLES_RST;
			gain_q          <= GAIN_RST;
			low_thr_q       <= LOW_THR_RST;
			crit_thr_q      <= CRIT_THR_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_BURST_SAMPLES: burst_samples_q <= cfg_data[BURST_W-1:0];
				REG_GAIN:          gain_q          <= cfg_data[GAIN_W-1:0];
				REG_LOW_THR:       low_thr_q       <= cfg_data[MV_W-1:0];
				REG_CRIT_THR:      crit_thr_q      <= cfg_data[MV_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_sum_q   <= '0;
			burst_count_q <= '0;
			wr_ptr_q      <= '0;
			fill_q        <= '0;
			hist_sum_q    <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (in_fire) begin
				burst_sum_q   <= burst_done ? '0 : sum_new;
				burst_count_q <= burst_done ? '0 : count_new;
			end
			if (state_q == ST_WRITE) begin
				hist_sum_q <= hist_sum_new;
				fill_q     <= fill_new;
				wr_ptr_q   <= (wr_ptr_q == PTR_W'(HISTORY_DEPTH - 1)) ? '0
				                                                  : wr_ptr_q + PTR_W'(1);
			end
			if (state_q == ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				div_quo_q <= DIV_W'(sum_new);
				div_rem_q <= '0;
				div_den_q <= count_new;
				div_cnt_q <= DCNT_W'(DIV_W);
			end
			ST_DIV_MEAN, ST_DIV_AVG: begin
				div_quo_q <= {div_quo_q[DIV_W-2:0], div_ge};
				div_rem_q <= div_rem_nxt;
				div_cnt_q <= div_cnt_q - DCNT_W'(1);
			end
			ST_MUL: begin
				product_q <= PROD_W'(div_quo_q[SAMPLE_W-1:0]) * PROD_W'(gain_q);
			end
			ST_WRITE: begin
				reading_q <= reading;
				div_quo_q <= DIV_W'(hist_sum_new);
				div_rem_q <= '0;
				div_den_q <= BURST_W'(fill_new);
				div_cnt_q <= DCNT_W'(DIV_W);
			end
			ST_EMIT: begin
				if (out_free) begin
					out_reading_q <= reading_q;
					out_avg_q     <= average;
					out_low_q     <= average <= low_thr_q;
					out_crit_q    <= average <= crit_thr_q;
				end
			end
			default: begin
			end
		endcase
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(HISTORY_DEPTH))
		else $error("history fill count beyond ring depth");

	a_ptr_tracks_fill: assert property (@(posedge clk) disable iff (!arst_n)
		!full |-> wr_ptr_q == PTR_W'(fill_q))
		else $error("write pointer out of step with fill count before wrap");

	a_burst_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		burst_count_q != '1)
		else $error("burst count reached its limit without closing a burst");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV_MEAN || state_q == ST_DIV_AVG) |->
			(div_den_q != '0 && div_rem_q < div_den_q))
		else $error("divider remainder not below divisor");

	a_result_after_write: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_EMIT)
		else $error("result word raised outside the emit step");

endmodule

// ===== rtl/bvavg_ram.sv =====
// bvavg_ram: generic single-clock ram, one write and one registered read port
// no dependencies
module bvavg_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
